// ===== hdl/bcim_pkg.sv =====
// Package: pattern tables, opcode map and shared types for the bus-cycle matcher.
package bcim_pkg;

  typedef enum logic [4:0] {
    PC_END, PC_1, PC_2, PC_3, PC_N, PC_LN, PC_A, PC_B, PC_Q, PC_E, PC_V, PC_R,
    PC_LR, PC_S, PC_W, PC_X, PC_F, PC_LW, PC_AT
  } pcode_t;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  typedef struct packed {
    logic        is_read;
    logic        is_write;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        last_cycle;
  } in_item_t;

  typedef struct packed {
    logic [7:0] matched_cycles;
    logic [1:0] instruction_length;
    logic [2:0] bus_cycle_count;
    logic [1:0] external_cycle_count;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pos;
    logic [15:0] nx;
    logic [15:0] opa;
    logic [7:0]  disp;
    logic [16:0] ra;
    logic [16:0] wa;
    logic [1:0]  status;
    logic [7:0]  result;
  } mstate_t;

  function automatic pcode_t chr2code(input byte c);
    case (c)
      "1": return PC_1;
      "2": return PC_2;
      "3": return PC_3;
      "N": return PC_N;
      "n": return PC_LN;
      "A", "P": return PC_A;
      "B": return PC_B;
      "Q": return PC_Q;
      "E": return PC_E;
      "V": return PC_V;
      "R": return PC_R;
      "r", "v", "e", "q": return PC_LR;
      "S": return PC_S;
      "s": return PC_END;
      "W": return PC_W;
      "X": return PC_X;
      "F": return PC_F;
      "w", "x", "f": return PC_LW;
      "@": return PC_AT;
      default: return PC_END;
    endcase
  endfunction

  function automatic string pat_str(input logic [4:0] s);
    case (s)
      5'd1: return "1N";          5'd2: return "1wWN@1N";
      5'd3: return "1WN@1N";      5'd4: return "1wWVvA@1VvA";
      5'd5: return "12wW3A@123A"; 5'd6: return "12wW3N@123N";
      5'd7: return "123A";        5'd8: return "123N";
      5'd9: return "12B";         5'd10: return "1Ss@1s";
      5'd11: return "1RN@1N";     5'd12: return "12N";
      5'd13: return "1RrN@1N";    5'd14: return "1n";
      5'd15: return "1RrP@1n";    5'd16: return "12n";
      5'd17: return "12QqN@12N";  5'd18: return "12RrN@12N";
      5'd19: return "12EeN@12N";  5'd20: return "12XxN@12N";
      5'd21: return "12WwN@12N";  5'd22: return "12FfN@12N";
      5'd23: return "12QXN@12N";  5'd24: return "12RWN@12N";
      5'd25: return "12EFN@12N";  5'd26: return "12QN@12N";
      5'd27: return "12RN@12N";   5'd28: return "12EN@12N";
      5'd29: return "12XN@12N";   5'd30: return "12WN@12N";
      5'd31: return "12FN@12N";
      default: return "";
    endcase
  endfunction

  // Pattern symbol at a position; 's' acts as a plain terminator in the model.
  function automatic pcode_t pat_code(input logic [4:0] s, input logic [3:0] p);
    string str;
    str = pat_str(s);
    if (int'(p) >= str.len()) return PC_END;
    return chr2code(str[p]);
  endfunction

  // Position just past the separator; 0 when the pattern has none.
  function automatic logic [3:0] sep_pos(input logic [4:0] s);
    case (s)
      5'd3, 5'd10, 5'd11: return 4'd4;
      5'd2, 5'd13, 5'd15: return 4'd5;
      5'd4, 5'd5, 5'd6: return 4'd7;
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: return 4'd6;
      5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31: return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

  localparam logic [1:0] LEN_TAB [32] = '{
    0,1,1,1,1,3,3,3,3,2,1,1,2,1,1,1,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2};
  localparam logic [2:0] BUSC_TAB [32] = '{
    0,1,3,2,5,5,5,3,3,2,2,2,2,3,1,3,2,4,4,4,4,4,4,4,4,4,3,3,3,3,3,3};
  localparam logic [1:0] EXTC_TAB [32] = '{
    0,1,1,1,3,3,3,3,3,2,1,1,2,1,1,1,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2};

  localparam logic [4:0] OP_SEQ [256] = '{
    1,1,0,0,0,0,1,1,2,1,3,1,1,1,1,1,
    4,4,4,4,4,4,4,4,4,4,4,4,4,4,4,4,
    5,0,6,6,7,8,8,8,0,0,0,0,1,9,10,10,
    1,1,1,1,0,0,0,0,11,12,13,12,1,1,1,1,
    1,0,0,0,14,1,1,1,1,0,0,0,14,1,1,1,
    1,0,0,0,2,0,2,2,1,0,0,0,15,0,13,13,
    1,0,0,0,9,0,16,16,0,0,0,0,9,0,16,16,
    1,0,0,0,9,0,16,16,1,0,0,0,9,0,16,16,
    17,18,18,18,8,19,18,18,20,21,21,21,0,22,21,21,
    23,24,24,24,0,25,24,24,23,24,24,24,0,25,24,24,
    17,18,18,18,8,19,18,18,0,0,0,0,0,0,0,0,
    17,18,18,18,8,19,18,18,17,18,18,18,8,19,18,18,
    26,27,27,27,12,28,27,27,29,30,30,30,0,31,30,30,
    26,27,27,27,12,28,27,27,26,27,27,27,12,28,27,27,
    0,27,27,27,12,28,27,27,0,0,0,0,0,0,0,0,
    26,27,27,27,12,28,27,27,27,27,27,27,12,28,27,27};

  // One matcher step for one captured cycle.
  function automatic mstate_t match_step(input mstate_t ms, input logic [4:0] seq,
                                         input in_item_t it, input logic [7:0] idx);
    mstate_t     o;
    pcode_t      c;
    logic [15:0] a, dsx, pcrel;
    logic [16:0] a17, dpage;
    logic        rv, wv, nxt, hit, rlow, wlow;
    o = ms;
    c = pat_code(seq, ms.pos);
    a = it.bus_address;
    a17 = {1'b0, a};
    dsx = {{8{ms.disp[7]}}, ms.disp};
    pcrel = ms.nx + dsx - 16'd1;
    dpage = 17'h0FF00 + {9'd0, ms.disp};
    rv = ms.ra[16];
    wv = ms.wa[16];
    nxt = 1'b0; hit = 1'b0; rlow = 1'b0; wlow = 1'b0;
    if (ms.status == ST_RUN) begin
      if (it.is_read) begin
        case (c)
          PC_1: begin o.nx = a + 16'd1; nxt = 1'b1; end
          PC_2: if (a == ms.nx) begin
            o.opa = {8'd0, it.bus_data}; o.disp = it.bus_data;
            o.nx = ms.nx + 16'd1; nxt = 1'b1;
          end
          PC_3: if (a == ms.nx) begin
            o.opa = ms.opa | {it.bus_data, 8'd0}; o.nx = ms.nx + 16'd1; nxt = 1'b1;
          end
          PC_N: hit = (a == ms.nx);
          PC_LN: hit = 1'b1;
          PC_A: hit = (a17 == {1'b0, ms.opa} + 17'd1);
          PC_B: hit = (a == ms.nx) || (a == ms.nx + dsx);
          PC_Q: rlow = (a == pcrel);
          PC_E: rlow = (a17 == dpage);
          PC_V: rlow = ((a & 16'hFFE1) == 16'h0020);
          PC_R: rlow = 1'b1;
          PC_LR: if (rv && a17 == {1'b0, ms.ra[15:0]} + 17'd1) begin
            o.opa = ms.opa | {it.bus_data, 8'd0}; nxt = 1'b1;
          end
          PC_S: begin
            if (!rv || a17 == {1'b0, ms.ra[15:0]} + 17'd1) begin
              o.ra = {1'b1, a}; o.opa = {8'd0, it.bus_data};
            end else if (a == ms.nx || a17 == {1'b0, ms.nx} + 17'd2) begin
              hit = 1'b1;
            end else begin
              o.status = ST_FAIL;
            end
          end
          default: ;
        endcase
        if (rlow) begin
          o.ra = {1'b1, a}; o.opa = {8'd0, it.bus_data}; nxt = 1'b1;
        end
      end else if (it.is_write) begin
        case (c)
          PC_W: wlow = !wv || (a17 + 17'd1 == {1'b0, ms.wa[15:0]}) ||
                       (rv && a == ms.ra[15:0]);
          PC_X: wlow = (a == pcrel);
          PC_F: wlow = (a17 == dpage);
          PC_LW: wlow = !wv || (a17 == {1'b0, ms.wa[15:0]} + 17'd1);
          default: ;
        endcase
        if (wlow) begin
          o.wa = {1'b1, a}; nxt = 1'b1;
        end
      end
      if (nxt) o.pos = ms.pos + 4'd1;
      else if (hit) begin o.status = ST_HIT; o.result = idx; end
      else if (c != PC_S || !it.is_read) o.status = ST_FAIL;
    end
    return o;
  endfunction

endpackage

// ===== hdl/bcim_if.sv =====
// Valid/ready channel interface carrying one item.
interface bcim_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bus_cycle_instruction_matcher_unit.sv =====
// Top level of the bus-cycle instruction matcher.
// Takes one captured bus cycle per clock (in_ channel) and, on the window's last cycle,
// gives one result: matched cycle count (full pattern preferred over the short one),
// instruction length and expected cycle counts. An item is taken every cycle while the
// output register is empty or being drained; each cycle's matcher step is a table lookup,
// address compares and 16-bit adds between the input register and the matcher state.
module bus_cycle_instruction_matcher_unit #(
  parameter int WINDOW_MAX = 255
) (
  input  logic clk,
  input  logic rst_n,
  bcim_if.sink   in_ch,
  bcim_if.source out_ch
);
  import bcim_pkg::*;

  localparam logic [7:0] WMAX = 8'(WINDOW_MAX);

  logic       in_v_r;
  in_item_t   in_r;
  logic [4:0] seq_r;
  logic [7:0] cyc_r;
  mstate_t    m0_r, m1_r;
  logic       out_v_r;
  out_item_t  out_r;

  logic       take, stage_go;
  logic [4:0] seq_nxt;
  logic [7:0] cyc_nxt;
  mstate_t    m0_b, m1_b, m0_nxt, m1_nxt;
  out_item_t  out_nxt;

  // stage advances when output register free or being drained
  assign stage_go = !out_v_r || out_ch.ready;
  assign in_ch.ready = stage_go || !in_v_r;
  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  always_comb begin
    logic [3:0] sp;
    sp = '0;
    seq_nxt = seq_r;
    m0_b = m0_r;
    m1_b = m1_r;
    if (cyc_r == 8'd0) begin
      seq_nxt = in_r.is_read ? OP_SEQ[in_r.bus_data] : 5'd0;
      sp = sep_pos(seq_nxt);
      m0_b = '0;
      m1_b = '0;
      m1_b.pos = sp;
      if (LEN_TAB[seq_nxt] != 2'd0) begin
        m1_b.status = (sp != 4'd0) ? ST_RUN : ST_FAIL;
      end else begin
        m0_b.status = ST_FAIL;
        m1_b.status = ST_FAIL;
        m1_b.pos = 4'd0;
      end
    end
    m0_nxt = m0_b;
    m1_nxt = m1_b;
    if (cyc_r < WMAX) begin
      m0_nxt = match_step(m0_b, seq_nxt, in_r, cyc_r);
      m1_nxt = match_step(m1_b, seq_nxt, in_r, cyc_r);
    end
    if (in_r.last_cycle) cyc_nxt = 8'd0;
    else cyc_nxt = (cyc_r < WMAX) ? cyc_r + 8'd1 : cyc_r;
    out_nxt.matched_cycles = (m0_nxt.status == ST_HIT) ? m0_nxt.result :
                             (m1_nxt.status == ST_HIT) ? m1_nxt.result : 8'd0;
    out_nxt.instruction_length = LEN_TAB[seq_nxt];
    out_nxt.bus_cycle_count = BUSC_TAB[seq_nxt];
    out_nxt.external_cycle_count = EXTC_TAB[seq_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      out_v_r <= 1'b0;
      seq_r <= '0;
      cyc_r <= '0;
      m0_r <= '0;
      m1_r <= '0;
    end else begin
      if (in_v_r && stage_go && in_r.last_cycle) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (in_v_r && stage_go) begin
        seq_r <= seq_nxt;
        cyc_r <= cyc_nxt;
        m0_r <= m0_nxt;
        m1_r <= m1_nxt;
        if (in_r.last_cycle) out_r <= out_nxt;
      end
      if (take) in_v_r <= 1'b1;
      else if (stage_go) in_v_r <= 1'b0;
    end
    if (take) in_r <= in_ch.data;
  end

endmodule

// ===== tb/bcim_result_checker.sv =====
// Checker: watches both channels, predicts match results per window and compares them.
`timescale 1ns / 100ps
module bcim_result_checker
  import bcim_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        err_cnt,
  output int        pending_cnt
);

  localparam int WIN_LIMIT = 255;

  typedef enum int {STEP_FAIL, STEP_NEXT, STEP_STAY, STEP_HIT} step_t;

  typedef struct {
    logic [3:0]  pos;
    logic [15:0] nfa;
    logic [15:0] opa;
    logic [7:0]  dp;
    logic [16:0] rda;
    logic [16:0] wra;
    logic [1:0]  st;
    logic [7:0]  res;
  } trk_t;

  string seq_pat [32] = '{
    "", "1N", "1wWN@1N", "1WN@1N", "1wWVvA@1VvA", "12wW3A@123A",
    "12wW3N@123N", "123A", "123N", "12B", "1Ss@1s", "1RN@1N", "12N",
    "1RrN@1N", "1n", "1RrP@1n", "12n", "12QqN@12N", "12RrN@12N",
    "12EeN@12N", "12XxN@12N", "12WwN@12N", "12FfN@12N", "12QXN@12N",
    "12RWN@12N", "12EFN@12N", "12QN@12N", "12RN@12N", "12EN@12N",
    "12XN@12N", "12WN@12N", "12FN@12N"};

  logic [1:0] len_tab [32] = '{
    0,1,1,1,1,3,3,3,3,2,1,1,2,1,1,1,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2};
  logic [2:0] bus_tab [32] = '{
    0,1,3,2,5,5,5,3,3,2,2,2,2,3,1,3,2,4,4,4,4,4,4,4,4,4,3,3,3,3,3,3};
  logic [1:0] ext_tab [32] = '{
    0,1,1,1,3,3,3,3,3,2,1,1,2,1,1,1,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2};

  logic [4:0] op_map [256] = '{
    1,1,0,0,0,0,1,1,2,1,3,1,1,1,1,1,
    4,4,4,4,4,4,4,4,4,4,4,4,4,4,4,4,
    5,0,6,6,7,8,8,8,0,0,0,0,1,9,10,10,
    1,1,1,1,0,0,0,0,11,12,13,12,1,1,1,1,
    1,0,0,0,14,1,1,1,1,0,0,0,14,1,1,1,
    1,0,0,0,2,0,2,2,1,0,0,0,15,0,13,13,
    1,0,0,0,9,0,16,16,0,0,0,0,9,0,16,16,
    1,0,0,0,9,0,16,16,1,0,0,0,9,0,16,16,
    17,18,18,18,8,19,18,18,20,21,21,21,0,22,21,21,
    23,24,24,24,0,25,24,24,23,24,24,24,0,25,24,24,
    17,18,18,18,8,19,18,18,0,0,0,0,0,0,0,0,
    17,18,18,18,8,19,18,18,17,18,18,18,8,19,18,18,
    26,27,27,27,12,28,27,27,29,30,30,30,0,31,30,30,
    26,27,27,27,12,28,27,27,26,27,27,27,12,28,27,27,
    0,27,27,27,12,28,27,27,0,0,0,0,0,0,0,0,
    26,27,27,27,12,28,27,27,27,27,27,27,12,28,27,27};

  logic [4:0] win_seq;
  logic [7:0] win_idx;
  trk_t       trk [2];
  out_item_t  expected_results [$];

  function automatic trk_t fresh_trk(input logic [3:0] start, input logic [1:0] st);
    trk_t t;
    t.pos = start; t.nfa = '0; t.opa = '0; t.dp = '0;
    t.rda = '0; t.wra = '0; t.st = st; t.res = '0;
    return t;
  endfunction

  function automatic trk_t track_cycle(input trk_t t, input logic [4:0] sq, input logic rd,
                                       input logic wr, input logic [15:0] a,
                                       input logic [7:0] d, input logic [7:0] idx);
    byte         c;
    logic [15:0] dsx, pcrel;
    int          ra, wa, dpage;
    bit          rv, wv, rlow, wlow;
    step_t       oc;
    string       p;
    p = seq_pat[sq];
    c = (int'(t.pos) < p.len()) ? p[t.pos] : 8'd0;
    ra = int'(t.rda[15:0]); rv = t.rda[16];
    wa = int'(t.wra[15:0]); wv = t.wra[16];
    dsx = {{8{t.dp[7]}}, t.dp};
    pcrel = t.nfa + dsx - 16'd1;
    dpage = 'hFF00 + int'(t.dp);
    oc = STEP_FAIL; rlow = 0; wlow = 0;
    if (t.st != ST_RUN) return t;
    if (rd) begin
      case (c)
        "1": begin t.nfa = a + 16'd1; oc = STEP_NEXT; end
        "2": if (a == t.nfa) begin
          t.opa = {8'd0, d}; t.dp = d; t.nfa = t.nfa + 16'd1; oc = STEP_NEXT;
        end
        "3": if (a == t.nfa) begin
          t.opa = t.opa | {d, 8'd0}; t.nfa = t.nfa + 16'd1; oc = STEP_NEXT;
        end
        "N": if (a == t.nfa) oc = STEP_HIT;
        "n": oc = STEP_HIT;
        "A", "P": if (int'(a) == int'(t.opa) + 1) oc = STEP_HIT;
        "B": if (a == t.nfa || a == t.nfa + dsx) oc = STEP_HIT;
        "Q": rlow = (a == pcrel);
        "E": rlow = (int'(a) == dpage);
        "V": rlow = ((a & 16'hFFE1) == 16'h0020);
        "R": rlow = 1;
        "r", "v", "e", "q": if (rv && int'(a) == ra + 1) begin
          t.opa = t.opa | {d, 8'd0}; oc = STEP_NEXT;
        end
        "S": begin
          if (!rv || int'(a) == ra + 1) begin
            t.rda = {1'b1, a}; t.opa = {8'd0, d}; oc = STEP_STAY;
          end else if (a == t.nfa || int'(a) == int'(t.nfa) + 2) begin
            oc = STEP_HIT;
          end
        end
        default: ;
      endcase
      if (rlow) begin
        t.rda = {1'b1, a}; t.opa = {8'd0, d}; oc = STEP_NEXT;
      end
    end else if (wr) begin
      case (c)
        "W": wlow = !wv || int'(a) + 1 == wa || (rv && int'(a) == ra);
        "X": wlow = (a == pcrel);
        "F": wlow = (int'(a) == dpage);
        "w", "x", "f": wlow = !wv || int'(a) == wa + 1;
        default: ;
      endcase
      if (wlow) begin
        t.wra = {1'b1, a}; oc = STEP_NEXT;
      end
    end
    case (oc)
      STEP_NEXT: t.pos = t.pos + 4'd1;
      STEP_HIT: begin t.st = ST_HIT; t.res = idx; end
      STEP_FAIL: t.st = ST_FAIL;
      default: ;
    endcase
    return t;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  initial begin
    err_cnt = 0;
    win_seq = '0;
    win_idx = '0;
    trk[0] = fresh_trk(4'd0, ST_RUN);
    trk[1] = fresh_trk(4'd0, ST_RUN);
  end

  assign pending_cnt = expected_results.size();

  always @(posedge clk) begin
    logic [3:0] sep;
    string      p;
    out_item_t  r;
    if (rst_n && in_valid && in_ready) begin
      if (win_idx == 8'd0) begin
        win_seq = in_data.is_read ? op_map[in_data.bus_data] : 5'd0;
        p = seq_pat[win_seq];
        sep = '0;
        for (int k = 0; k < p.len(); k++) begin
          if (p[k] == "@") begin
            sep = 4'(k + 1);
            break;
          end
        end
        if (len_tab[win_seq] != 0) begin
          trk[0] = fresh_trk(4'd0, ST_RUN);
          trk[1] = fresh_trk(sep, (sep != 0) ? ST_RUN : ST_FAIL);
        end else begin
          trk[0] = fresh_trk(4'd0, ST_FAIL);
          trk[1] = fresh_trk(4'd0, ST_FAIL);
        end
      end
      if (win_idx < WIN_LIMIT) begin
        for (int m = 0; m < 2; m++)
          trk[m] = track_cycle(trk[m], win_seq, in_data.is_read, in_data.is_write,
                               in_data.bus_address, in_data.bus_data, win_idx);
      end
      if (!in_data.last_cycle) begin
        if (win_idx < WIN_LIMIT) win_idx = win_idx + 8'd1;
      end else begin
        // Full pattern wins over the short one.
        r.matched_cycles = (trk[0].st == ST_HIT) ? trk[0].res :
                           (trk[1].st == ST_HIT) ? trk[1].res : 8'd0;
        r.instruction_length = len_tab[win_seq];
        r.bus_cycle_count = bus_tab[win_seq];
        r.external_cycle_count = ext_tab[win_seq];
        expected_results.push_back(r);
        win_idx = 8'd0;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result item with no expectation pending", $time);
        err_cnt++;
      end else begin
        r = expected_results.pop_front();
        if (out_data.matched_cycles !== r.matched_cycles)
          report("matched_cycles", out_data.matched_cycles, r.matched_cycles);
        if (out_data.instruction_length !== r.instruction_length)
          report("instruction_length", out_data.instruction_length, r.instruction_length);
        if (out_data.bus_cycle_count !== r.bus_cycle_count)
          report("bus_cycle_count", out_data.bus_cycle_count, r.bus_cycle_count);
        if (out_data.external_cycle_count !== r.external_cycle_count)
          report("external_cycle_count", out_data.external_cycle_count,
                 r.external_cycle_count);
      end
    end
  end

endmodule

// ===== tb/bus_cycle_instruction_matcher_unit_tb.sv =====
// Testbench top: clock, reset, bus-cycle window stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module bus_cycle_instruction_matcher_unit_tb;
  import bcim_pkg::*;

  logic clk;
  logic rst_n;
  int   err_cnt, pending_cnt;
  int   items_sent;
  bit   calm;

  bcim_if #(.T(in_item_t))  in_ch();
  bcim_if #(.T(out_item_t)) out_ch();

  bus_cycle_instruction_matcher_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bcim_result_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .err_cnt     (err_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off to back up the input.
  initial begin
    int  gap;
    bit  held;
    held = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_sent > 300) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_cycle(input in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic in_item_t mk(input logic rd, input logic wr, input logic [15:0] a,
                                  input logic [7:0] d);
    in_item_t it;
    it.is_read = rd; it.is_write = wr; it.bus_address = a; it.bus_data = d;
    it.last_cycle = 1'b0;
    return it;
  endfunction

  function automatic in_item_t mk_rand();
    return mk(1'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  task automatic send_window(input in_item_t win [$]);
    win[win.size() - 1].last_cycle = 1'b1;
    foreach (win[k]) send_cycle(win[k]);
  endtask

  // Build a window that follows the opcode's bus pattern, then maybe damage it.
  task automatic pattern_window(input logic [7:0] op_in, input logic [15:0] pc);
    in_item_t    win [$];
    in_item_t    it;
    logic [7:0]  op, dp, d;
    logic [4:0]  sq;
    logic [15:0] nx, opa, lra, lwa, a, base;
    bit          wv, short_part;
    string       p;
    int          k, n;
    op = op_in;
    sq = u_chk.op_map[op];
    p = u_chk.seq_pat[sq];
    short_part = ($urandom_range(0, 9) < 3);
    k = 0;
    if (short_part) begin
      while (k < p.len() && p[k] != "@") k++;
      if (k < p.len()) k++;
      else k = 0;
    end
    nx = 0; opa = 0; dp = 0; lra = 0; lwa = 0; wv = 0;
    for (; k < p.len() && p[k] != "@"; k++) begin
      d = 8'($urandom);
      case (p[k])
        "1": begin win.push_back(mk(1, 0, pc, op)); nx = pc + 16'd1; end
        "2": begin win.push_back(mk(1, 0, nx, d)); opa = {8'd0, d}; dp = d; nx++; end
        "3": begin win.push_back(mk(1, 0, nx, d)); opa = opa | {d, 8'd0}; nx++; end
        "N": win.push_back(mk(1, 0, nx, d));
        "n": win.push_back(mk(1, 0, 16'($urandom), d));
        "A", "P": win.push_back(mk(1, 0, opa + 16'd1, d));
        "B": win.push_back(mk(1, 0, $urandom_range(0, 1) ? nx : nx + {{8{dp[7]}}, dp}, d));
        "Q", "E", "V", "R": begin
          a = (p[k] == "Q") ? nx + {{8{dp[7]}}, dp} - 16'd1 :
              (p[k] == "E") ? 16'hFF00 + {8'd0, dp} :
              (p[k] == "V") ? (16'h0020 | (16'($urandom) & 16'h001E)) : 16'($urandom);
          win.push_back(mk(1, 0, a, d));
          lra = a; opa = {8'd0, d};
        end
        "r", "v", "e", "q": begin
          win.push_back(mk(1, 0, lra + 16'd1, d)); opa = opa | {d, 8'd0};
        end
        "S": begin
          base = 16'($urandom);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) win.push_back(mk(1, 0, base + 16'(i), 8'($urandom)));
          win.push_back(mk(1, 0, $urandom_range(0, 1) ? nx : nx + 16'd2, d));
        end
        "W": begin
          a = !wv ? 16'($urandom) : ($urandom_range(0, 1) ? lwa - 16'd1 : lra);
          win.push_back(mk(0, 1, a, d)); lwa = a; wv = 1;
        end
        "w", "x", "f": begin
          a = wv ? lwa + 16'd1 : 16'($urandom);
          win.push_back(mk(0, 1, a, d)); lwa = a; wv = 1;
        end
        "X": begin
          a = nx + {{8{dp[7]}}, dp} - 16'd1;
          win.push_back(mk(0, 1, a, d)); lwa = a; wv = 1;
        end
        "F": begin
          a = 16'hFF00 + {8'd0, dp};
          win.push_back(mk(0, 1, a, d)); lwa = a; wv = 1;
        end
        default: ;
      endcase
    end
    if (win.size() == 0) win.push_back(mk(1, 0, pc, op));
    // Damage one field of one cycle now and then.
    if (win.size() > 1 && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, win.size() - 1);
      case ($urandom_range(0, 3))
        0: win[n].bus_address ^= 16'(1 << $urandom_range(0, 15));
        1: win[n].is_read = ~win[n].is_read;
        2: win[n].is_write = ~win[n].is_write;
        default: win[n].bus_data = 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) win.push_back(mk_rand());
    end else if (win.size() > 1 && $urandom_range(0, 8) == 0) begin
      void'(win.pop_back());
    end
    send_window(win);
  endtask

  task automatic noise_window(input int len);
    in_item_t win [$];
    for (int i = 0; i < len; i++) win.push_back(mk_rand());
    send_window(win);
  endtask

  function automatic logic [7:0] valid_opcode();
    logic [7:0] op;
    do op = 8'($urandom); while (u_chk.op_map[op] == 0);
    return op;
  endfunction

  function automatic logic [15:0] pick_pc();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t win [$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    items_sent = 0;
    calm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first cycle a write, invalid opcode, both flags, neither flag.
    win = {mk(0, 1, 16'h1234, 8'h01), mk(1, 0, 16'h1235, 8'h00)};
    send_window(win);
    win = {mk(1, 0, 16'h2000, 8'h02), mk(1, 0, 16'h2001, 8'h00)};
    send_window(win);
    win = {mk(1, 1, 16'hFFFF, 8'hFF), mk(1, 1, 16'h0000, 8'h00), mk(1, 0, 16'h0001, 8'hFF)};
    send_window(win);
    win = {mk(1, 0, 16'h4000, 8'hC0), mk(0, 0, 16'h4001, 8'h80)};
    send_window(win);
    win = {mk(0, 0, 16'h0000, 8'h00)};
    send_window(win);
    pattern_window(8'h2E, 16'h8000);  // sequential search
    pattern_window(8'h10, 16'hFFFF);  // vector call at the top of memory
    pattern_window(8'h20, 16'hFFFE);  // three-byte call that wraps
    pattern_window(8'h93, 16'h0000);

    while (items_sent < 1500) begin
      if (items_sent > 1300) calm = 1;
      case ($urandom_range(0, 19))
        0, 1: noise_window($urandom_range(1, 8));
        2: if ($urandom_range(0, 9) == 0) begin
          // Window longer than the matcher tracks.
          win = {mk(1, 0, pick_pc(), valid_opcode())};
          repeat ($urandom_range(255, 290)) win.push_back(mk_rand());
          send_window(win);
        end
        3: pattern_window(8'($urandom), pick_pc());
        default: pattern_window(valid_opcode(), pick_pc());
      endcase
    end
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bus_cycle_instruction_matcher_unit.f =====
hdl/bcim_pkg.sv
hdl/bcim_if.sv
hdl/bus_cycle_instruction_matcher_unit.sv
tb/bcim_result_checker.sv
tb/bus_cycle_instruction_matcher_unit_tb.sv
